// File: rtl/ibus_frame_receiver_macros.svh
// assertion helpers shared by the receiver modules
// each expects clk and rst_n in the enclosing module
`ifndef IBUS_FRAME_RECEIVER_MACROS_SVH
`define IBUS_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define IBFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IBFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ibfr_pkg.sv
package ibfr_pkg;

    // frame geometry
    localparam int CHANNELS  = 14;
    localparam int FRAME_LEN = 4 + 2 * CHANNELS;
    localparam int SUM_LEN   = 2 + 2 * CHANNELS;
    localparam int FB_AW     = $clog2(FRAME_LEN);
    localparam int COUNT_W   = 6;

    // register port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // result widths
    localparam int DRIVE_W   = 11;
    localparam int SW_W      = 6;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    // drive command of a channel at zero, the reset value of the latched set
    localparam logic signed [DRIVE_W-1:0] DRIVE_FLOOR = -11'sd1000;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_IDLE = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } ibfr_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_LIMIT = 2'd0,
        REG_HEADER_LENGTH = 2'd1,
        REG_HEADER_TYPE   = 2'd2
    } ibfr_reg_t;

    typedef enum logic [1:0] {
        OP_SHOW  = 2'd0,
        OP_LATCH = 2'd1,
        OP_TICK  = 2'd2
    } ibfr_op_t;

    typedef struct packed {
        logic [15:0] timeout_limit;
        logic [7:0]  header_length;
        logic [7:0]  header_type;
    } ibfr_cfg_t;

    typedef struct packed {
        ibfr_op_t                   op;
        logic signed [DRIVE_W-1:0]  drive_one;
        logic signed [DRIVE_W-1:0]  drive_two;
        logic [SW_W-1:0]            switches;
    } ibfr_entry_t;

endpackage

// File: rtl/ibfr_queue.sv
`include "ibus_frame_receiver_macros.svh"

module ibfr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ibfr_pkg::ibfr_entry_t push_entry,
    input  logic                 pop,
    output logic                 empty,
    output ibfr_pkg::ibfr_entry_t pop_entry
);
    import ibfr_pkg::*;

    ibfr_entry_t         slot_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg;
    logic [Q_AW-1:0]     rd_ptr_reg;
    logic [Q_CW-1:0]     cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (cnt_reg == Q_CW'(QUEUE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointer advance with wrap
    function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
        logic [Q_AW-1:0] r;
        if (p == Q_AW'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    `IBFR_ASSERT_NEXT(a_q_grow, (do_push && !do_pop), (cnt_reg == $past(cnt_reg) + 1'b1), "queue count did not grow on push")

endmodule

// File: rtl/ibfr_front.sv
`include "ibus_frame_receiver_macros.svh"

module ibfr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ibfr_pkg::ibfr_cfg_t   cfg,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            command,
    input  logic [7:0]            rx_byte,
    output logic                  q_push,
    input  logic                  q_full,
    output ibfr_pkg::ibfr_entry_t q_entry
);
    import ibfr_pkg::*;

    // frame positions of channels 1, 2, 7, 8, 9 and 10
    localparam int PICK [6] = '{0, 1, 6, 7, 8, 9};

    logic [7:0]         fb_reg [FRAME_LEN];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [15:0]        sum_reg;
    logic [15:0]        sum_next;
    logic               in_fire;
    ibfr_cmd_t          cmd;
    logic               frame_ok;
    logic [15:0]        trailer;
    logic [15:0]        chan [6];
    logic [9:0]         scaled [6];

    // clamp(v - 1000, 0, 1000)
    function automatic logic [9:0] chan_scale(input logic [15:0] v);
        logic [15:0] d;
        logic [9:0]  r;
        d = v - 16'd1000;
        if (v < 16'd1000)
            r = '0;
        else if (v > 16'd2000)
            r = 10'd1000;
        else
            r = d[9:0];
        return r;
    endfunction

    // (c - 500) * 2
    function automatic logic [DRIVE_W-1:0] chan_drive(input logic [9:0] c);
        logic [DRIVE_W-1:0] r;
        r = {c, 1'b0} - 11'd1000;
        return r;
    endfunction

    function automatic logic two_pos(input logic [9:0] c);
        logic r;
        r = (c > 10'd850);
        return r;
    endfunction

    function automatic logic [1:0] three_pos(input logic [9:0] c);
        logic [1:0] r;
        if (c < 10'd250)
            r = 2'd0;
        else if (c < 10'd850)
            r = 2'd1;
        else
            r = 2'd2;
        return r;
    endfunction

    assign full    = q_full;
    assign in_fire = push && !q_full;
    assign q_push  = in_fire;
    assign cmd     = ibfr_cmd_t'(command);

    // frame check on the stored burst
    assign trailer  = {fb_reg[FRAME_LEN-1], fb_reg[FRAME_LEN-2]};
    assign frame_ok = (count_reg == COUNT_W'(FRAME_LEN))
                   && (fb_reg[0] == cfg.header_length)
                   && (fb_reg[1] == cfg.header_type)
                   && ((16'hFFFF - sum_reg) == trailer);

    // channel pick and scaling
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            chan[i]   = {fb_reg[FB_AW'(2 + 2 * PICK[i] + 1)], fb_reg[FB_AW'(2 + 2 * PICK[i])]};
            scaled[i] = chan_scale(chan[i]);
        end
    end

    // classify the item for the back end
    always_comb
    begin
        q_entry.drive_one = chan_drive(scaled[0]);
        q_entry.drive_two = chan_drive(scaled[1]);
        q_entry.switches  = {two_pos(scaled[5]), three_pos(scaled[4]),
                             three_pos(scaled[3]), two_pos(scaled[2])};
        unique case (cmd)
            CMD_IDLE: q_entry.op = frame_ok ? OP_LATCH : OP_SHOW;
            CMD_TICK: q_entry.op = OP_TICK;
            default:  q_entry.op = OP_SHOW;
        endcase
    end

    // burst count and checksum
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (in_fire)
        begin
            unique case (cmd)
                CMD_BYTE:
                begin
                    if (count_reg < COUNT_W'(SUM_LEN))
                        sum_next = sum_reg + {8'd0, rx_byte};
                    if (count_reg != '1)
                        count_next = count_reg + 1'b1;
                end
                CMD_IDLE:
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // burst byte store
    always_ff @(posedge clk)
    begin
        if (in_fire && (cmd == CMD_BYTE) && (count_reg < COUNT_W'(FRAME_LEN)))
            fb_reg[count_reg[FB_AW-1:0]] <= rx_byte;
    end

    `IBFR_ASSERT_NEXT(a_idle_restart, (in_fire && cmd == CMD_IDLE), (count_reg == '0 && sum_reg == '0), "burst not restarted after idle")

endmodule

// File: rtl/ibfr_back.sv
`include "ibus_frame_receiver_macros.svh"

module ibfr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ibfr_pkg::ibfr_cfg_t        cfg,
    input  logic                       q_empty,
    input  ibfr_pkg::ibfr_entry_t      q_entry,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [ibfr_pkg::DRIVE_W-1:0] command_one,
    output logic signed [ibfr_pkg::DRIVE_W-1:0] command_two,
    output logic [ibfr_pkg::SW_W-1:0]  switch_state,
    output logic                       link_lost,
    output logic                       frame_accepted
);
    import ibfr_pkg::*;

    logic signed [DRIVE_W-1:0] lat_one_reg, lat_one_next;
    logic signed [DRIVE_W-1:0] lat_two_reg, lat_two_next;
    logic [SW_W-1:0]           lat_sw_reg, lat_sw_next;
    logic signed [DRIVE_W-1:0] held_one_reg, held_one_next;
    logic signed [DRIVE_W-1:0] held_two_reg, held_two_next;
    logic [SW_W-1:0]           held_sw_reg, held_sw_next;
    logic [15:0]               tcount_reg, tcount_next;
    logic                      tflag_reg, tflag_next;
    logic                      acc_next;
    logic                      out_valid_reg;

    assign q_pop = !q_empty && (!out_valid_reg || pop);
    assign empty = !out_valid_reg;

    // apply one queued item
    always_comb
    begin
        lat_one_next  = lat_one_reg;
        lat_two_next  = lat_two_reg;
        lat_sw_next   = lat_sw_reg;
        held_one_next = held_one_reg;
        held_two_next = held_two_reg;
        held_sw_next  = held_sw_reg;
        tcount_next   = tcount_reg;
        tflag_next    = tflag_reg;
        acc_next      = 1'b0;
        if (q_pop)
        begin
            unique case (q_entry.op)
                OP_LATCH:
                begin
                    lat_one_next = q_entry.drive_one;
                    lat_two_next = q_entry.drive_two;
                    lat_sw_next  = q_entry.switches;
                    tcount_next  = '0;
                    tflag_next   = 1'b0;
                    acc_next     = 1'b1;
                end
                OP_TICK:
                begin
                    if (!tflag_reg)
                    begin
                        held_one_next = lat_one_reg;
                        held_two_next = lat_two_reg;
                        held_sw_next  = lat_sw_reg;
                    end
                    if (tcount_reg >= cfg.timeout_limit)
                    begin
                        tflag_next    = 1'b1;
                        tcount_next   = cfg.timeout_limit;
                        held_one_next = '0;
                        held_two_next = '0;
                        held_sw_next[0] = 1'b0;
                    end
                    else
                    begin
                        tcount_next = tcount_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_one_reg   <= DRIVE_FLOOR;
            lat_two_reg   <= DRIVE_FLOOR;
            lat_sw_reg    <= '0;
            held_one_reg  <= '0;
            held_two_reg  <= '0;
            held_sw_reg   <= '0;
            tcount_reg    <= '0;
            tflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lat_one_reg  <= lat_one_next;
            lat_two_reg  <= lat_two_next;
            lat_sw_reg   <= lat_sw_next;
            held_one_reg <= held_one_next;
            held_two_reg <= held_two_next;
            held_sw_reg  <= held_sw_next;
            tcount_reg   <= tcount_next;
            tflag_reg    <= tflag_next;
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            command_one    <= held_one_next;
            command_two    <= held_two_next;
            switch_state   <= held_sw_next;
            link_lost      <= tflag_next;
            frame_accepted <= acc_next;
        end
    end

    `IBFR_ASSERT_IMPL(a_lost_zero, tflag_reg, (held_one_reg == '0 && held_two_reg == '0 && held_sw_reg[0] == 1'b0), "drive not zero while link lost")
    `IBFR_ASSERT_NEXT(a_latch_clears, (q_pop && q_entry.op == OP_LATCH), (!tflag_reg && tcount_reg == '0), "valid frame did not clear timeout")

endmodule

// File: rtl/ibus_frame_receiver.sv
// flow: an accepted item is written into the queue and popped into the result register when that
// register is empty or its result is being taken by pop
// throughput: one item per cycle while the queue is not full; each item yields exactly one result
// a two-entry queue splits frame capture from the tick/timeout unit, result held in a register
// reset (rst_n low, asynchronous): burst, timeout and held outputs cleared, registers to
// their defaults; the stored frame bytes are not cleared and need no clearing pass
module ibus_frame_receiver (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           command,
    input  logic [7:0]                           rx_byte,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [ibfr_pkg::DRIVE_W-1:0]  command_one,
    output logic signed [ibfr_pkg::DRIVE_W-1:0]  command_two,
    output logic [ibfr_pkg::SW_W-1:0]            switch_state,
    output logic                                 link_lost,
    output logic                                 frame_accepted,
    input  logic                                 cfg_write,
    input  logic [ibfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ibfr_pkg::CFG_W-1:0]           cfg_data
);
    import ibfr_pkg::*;

    ibfr_cfg_t   cfg_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    ibfr_entry_t q_in;
    ibfr_entry_t q_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit <= 16'd160;
            cfg_reg.header_length <= 8'd32;
            cfg_reg.header_type   <= 8'd64;
        end
        else if (cfg_write)
        begin
            unique case (ibfr_reg_t'(cfg_index))
                REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_data;
                REG_HEADER_LENGTH: cfg_reg.header_length <= cfg_data[7:0];
                REG_HEADER_TYPE:   cfg_reg.header_type   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // byte capture and frame check
    ibfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .command (command),
        .rx_byte (rx_byte),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_entry (q_in)
    );

    // decoupling queue
    ibfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .full       (q_full),
        .push_entry (q_in),
        .pop        (q_pop),
        .empty      (q_empty),
        .pop_entry  (q_out)
    );

    // tick, timeout and result register
    ibfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_entry        (q_out),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .command_one    (command_one),
        .command_two    (command_two),
        .switch_state   (switch_state),
        .link_lost      (link_lost),
        .frame_accepted (frame_accepted)
    );

endmodule

// File: dv/ibus_frame_receiver_tb.sv
`timescale 1ns / 1ps

module ibus_frame_receiver_tb;

    import ibfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] one;
        logic signed [DRIVE_W-1:0] two;
        logic [SW_W-1:0]           sw;
        logic                      lost;
        logic                      accepted;
    } rx_result_t;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_HEADER,
        FRAME_BAD_SUM
    } frame_kind_t;

    // predictor of the receiver outputs and the queue of outputs still awaited
    class receiver_scoreboard;
        logic [15:0]               limit_reg;
        logic [7:0]                hdr_len;
        logic [7:0]                hdr_type;
        logic [7:0]                frame_mem [FRAME_LEN];
        logic [5:0]                burst_len;
        logic [15:0]               byte_sum;
        logic [15:0]               chan_hold [6];
        logic [15:0]               tick_count;
        logic                      lost;
        logic signed [DRIVE_W-1:0] drive_one;
        logic signed [DRIVE_W-1:0] drive_two;
        logic [SW_W-1:0]           switches;
        rx_result_t                awaited_outputs [$];
        int                        errors;
        int                        n_items;
        int                        n_results;
        int                        n_frames;
        int                        n_lost;

        function new();
            limit_reg  = 16'd160;
            hdr_len    = 8'd32;
            hdr_type   = 8'd64;
            burst_len  = '0;
            byte_sum   = '0;
            tick_count = '0;
            lost       = 1'b0;
            drive_one  = '0;
            drive_two  = '0;
            switches   = '0;
            foreach (frame_mem[i]) frame_mem[i] = '0;
            foreach (chan_hold[i]) chan_hold[i] = '0;
            errors    = 0;
            n_items   = 0;
            n_results = 0;
            n_frames  = 0;
            n_lost    = 0;
        endfunction

        function void write_reg(ibfr_reg_t idx, logic [15:0] val);
            case (idx)
                REG_TIMEOUT_LIMIT: limit_reg = val;
                REG_HEADER_LENGTH: hdr_len   = val[7:0];
                REG_HEADER_TYPE:   hdr_type  = val[7:0];
                default: ;
            endcase
        endfunction

        // channel value to 0..1000 after removing the 1000 offset
        function int scaled(logic [15:0] v);
            int c;
            c = v;
            c = c - 1000;
            if (c < 0) c = 0;
            if (c > 1000) c = 1000;
            return c;
        endfunction

        function logic [1:0] level3(int c);
            if (c < 250) return 2'd0;
            if (c < 850) return 2'd1;
            return 2'd2;
        endfunction

        // advance the model by one accepted item and queue its output
        function void note_item(ibfr_cmd_t cmd, logic [7:0] b);
            rx_result_t  exp;
            logic        ok;
            logic [15:0] trailer;
            int          c [6];
            int          d;
            int          p;
            ok = 1'b0;
            case (cmd)
                CMD_BYTE:
                begin
                    if (burst_len < FRAME_LEN) frame_mem[burst_len] = b;
                    if (burst_len < SUM_LEN) byte_sum = byte_sum + 16'(b);
                    if (burst_len < 63) burst_len++;
                end
                CMD_IDLE:
                begin
                    trailer = {frame_mem[FRAME_LEN-1], frame_mem[FRAME_LEN-2]};
                    if (burst_len == FRAME_LEN && frame_mem[0] == hdr_len &&
                        frame_mem[1] == hdr_type && 16'(16'hFFFF - byte_sum) == trailer)
                    begin
                        // latch ch1, ch2, ch7..ch10
                        for (int i = 0; i < 6; i++)
                        begin
                            p = 2 + 2 * ((i < 2) ? i : i + 4);
                            chan_hold[i] = {frame_mem[p+1], frame_mem[p]};
                        end
                        tick_count = '0;
                        lost       = 1'b0;
                        ok         = 1'b1;
                    end
                    burst_len = '0;
                    byte_sum  = '0;
                end
                CMD_TICK:
                begin
                    if (!lost)
                    begin
                        for (int i = 0; i < 6; i++) c[i] = scaled(chan_hold[i]);
                        d = (c[0] - 500) * 2;
                        drive_one = d[DRIVE_W-1:0];
                        d = (c[1] - 500) * 2;
                        drive_two = d[DRIVE_W-1:0];
                        switches = {(c[5] > 850), level3(c[4]), level3(c[3]), (c[2] > 850)};
                    end
                    // saturating timeout
                    if (tick_count >= limit_reg)
                    begin
                        lost        = 1'b1;
                        tick_count  = limit_reg;
                        drive_one   = '0;
                        drive_two   = '0;
                        switches[0] = 1'b0;
                    end
                    else
                    begin
                        tick_count++;
                    end
                end
                default: ;
            endcase
            if (cmd != CMD_NONE) n_items++;
            if (ok) n_frames++;
            if (lost) n_lost++;
            exp.one      = drive_one;
            exp.two      = drive_two;
            exp.sw       = switches;
            exp.lost     = lost;
            exp.accepted = ok;
            awaited_outputs.push_back(exp);
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t exp;
            if (awaited_outputs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected output one=%0d two=%0d sw=%b lost=%b acc=%b",
                             $realtime, got.one, got.two, got.sw, got.lost, got.accepted);
                return;
            end
            exp = awaited_outputs.pop_front();
            n_results++;
            if (got.one !== exp.one || got.two !== exp.two || got.sw !== exp.sw ||
                got.lost !== exp.lost || got.accepted !== exp.accepted)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: output %0d mismatch", $realtime, n_results);
                    $display("  expected one=%0d two=%0d sw=%b lost=%b acc=%b",
                             exp.one, exp.two, exp.sw, exp.lost, exp.accepted);
                    $display("  actual   one=%0d two=%0d sw=%b lost=%b acc=%b",
                             got.one, got.two, got.sw, got.lost, got.accepted);
                end
            end
        endfunction

        function int pending();
            return awaited_outputs.size();
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    logic                      full;
    logic [1:0]                command   = CMD_NONE;
    logic [7:0]                rx_byte   = 8'h00;
    logic                      empty;
    logic                      pop       = 1'b0;
    logic signed [DRIVE_W-1:0] command_one;
    logic signed [DRIVE_W-1:0] command_two;
    logic [SW_W-1:0]           switch_state;
    logic                      link_lost;
    logic                      frame_accepted;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_TIMEOUT_LIMIT;
    logic [CFG_W-1:0]          cfg_data  = '0;

    bit                        tx_steady = 1'b0;
    bit                        rx_steady = 1'b0;
    bit                        hold_req  = 1'b0;
    int                        stall_cycles = 0;

    receiver_scoreboard sb;

    ibus_frame_receiver u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .command_one    (command_one),
        .command_two    (command_two),
        .switch_state   (switch_state),
        .link_lost      (link_lost),
        .frame_accepted (frame_accepted),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // offer one item, with random gaps, and wait until it is taken
    task automatic send_item(ibfr_cmd_t cmd, logic [7:0] b);
        while (!tx_steady && $urandom_range(0, 99) < 36)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push    = 1'b1;
        command = cmd;
        rx_byte = b;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_item(cmd, b);
        @(negedge clk);
    endtask

    // register write once every awaited output is out and the pipe has drained
    task automatic write_reg(ibfr_reg_t idx, logic [15:0] val);
        push = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(logic [15:0] limit, logic [7:0] hlen, logic [7:0] htype);
        write_reg(REG_TIMEOUT_LIMIT, limit);
        write_reg(REG_HEADER_LENGTH, {8'h00, hlen});
        write_reg(REG_HEADER_TYPE, {8'h00, htype});
    endtask

    // channel values biased to the clamp and switch thresholds
    function automatic logic [15:0] pick_chan();
        case ($urandom_range(0, 7))
            0: return 16'($urandom);
            1: return 16'(999 + $urandom_range(0, 2));
            2: return 16'(1249 + $urandom_range(0, 2));
            3: return 16'(1849 + $urandom_range(0, 2));
            4: return 16'(1999 + $urandom_range(0, 2));
            5: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'(1000 + $urandom_range(0, 1000));
        endcase
    endfunction

    // one frame burst and its closing idle item, a tick optionally slipped in
    task automatic send_frame(frame_kind_t kind, logic [15:0] chans [CHANNELS], int tick_at);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] sum;
        int          k;
        int          bitpos;
        fb[0] = sb.hdr_len;
        fb[1] = sb.hdr_type;
        for (int i = 0; i < CHANNELS; i++)
        begin
            fb[2+2*i] = chans[i][7:0];
            fb[3+2*i] = chans[i][15:8];
        end
        if (kind == FRAME_BAD_HEADER)
        begin
            k = $urandom_range(0, 1);
            bitpos = $urandom_range(0, 7);
            fb[k][bitpos] = ~fb[k][bitpos];
        end
        sum = '0;
        for (int i = 0; i < SUM_LEN; i++) sum = sum + 16'(fb[i]);
        sum = 16'hFFFF - sum;
        fb[FRAME_LEN-2] = sum[7:0];
        fb[FRAME_LEN-1] = sum[15:8];
        if (kind == FRAME_BAD_SUM)
        begin
            k = $urandom_range(2, FRAME_LEN - 1);
            bitpos = $urandom_range(0, 7);
            fb[k][bitpos] = ~fb[k][bitpos];
        end
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i == tick_at) send_item(CMD_TICK, 8'($urandom));
            send_item(CMD_BYTE, fb[i]);
        end
        send_item(CMD_IDLE, 8'($urandom));
    endtask

    // mostly good frames, with broken bursts, junk and tick runs mixed in
    task automatic run_random(int count);
        int          goal;
        int          r;
        int          n;
        logic [15:0] chans [CHANNELS];
        goal = sb.n_items + count;
        while (sb.n_items < goal)
        begin
            r = $urandom_range(0, 99);
            for (int i = 0; i < CHANNELS; i++) chans[i] = pick_chan();
            if (r < 60)
            begin
                n = -1;
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, FRAME_LEN - 1);
                send_frame(FRAME_GOOD, chans, n);
            end
            else if (r < 70)
            begin
                send_frame(FRAME_BAD_HEADER, chans, -1);
            end
            else if (r < 76)
            begin
                send_frame(FRAME_BAD_SUM, chans, -1);
            end
            else if (r < 87)
            begin
                // short or long burst
                n = (r < 82) ? $urandom_range(0, FRAME_LEN - 1) : $urandom_range(FRAME_LEN + 1, 70);
                for (int i = 0; i < n; i++) send_item(CMD_BYTE, 8'($urandom));
                send_item(CMD_IDLE, 8'($urandom));
            end
            else if (r < 93)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(ibfr_cmd_t'($urandom_range(0, 3)), 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(5, 40)) send_item(CMD_TICK, 8'($urandom));
            end
            repeat ($urandom_range(0, 4)) send_item(CMD_TICK, 8'($urandom));
        end
    endtask

    // result side: random pops, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop = 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                pop = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_req = 1'b0;
            end
            else
            begin
                pop = rx_steady || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // check each output item taken
    always @(posedge clk)
    begin
        rx_result_t got;
        if (rst_n && pop && !empty)
        begin
            got.one      = command_one;
            got.two      = command_two;
            got.sw       = switch_state;
            got.lost     = link_lost;
            got.accepted = frame_accepted;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] chans [CHANNELS];
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: tick from reset, unused command, empty burst
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_NONE, 8'hFF);
        send_item(CMD_IDLE, 8'h00);
        // valid frame with clamp and switch threshold values
        for (int i = 0; i < CHANNELS; i++) chans[i] = pick_chan();
        chans[0] = 16'h0000;
        chans[1] = 16'hFFFF;
        chans[6] = 16'd1851;
        chans[7] = 16'd1250;
        chans[8] = 16'd1850;
        chans[9] = 16'd1850;
        send_frame(FRAME_GOOD, chans, -1);
        send_item(CMD_TICK, 8'hA5);
        // short burst
        send_item(CMD_BYTE, 8'd32);
        send_item(CMD_BYTE, 8'd64);
        send_item(CMD_IDLE, 8'h5A);
        send_item(CMD_TICK, 8'h00);

        // reset settings
        run_random(350);

        // zero timeout, header extremes; output held off while input keeps coming
        set_config(16'd0, 8'h00, 8'hFF);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < CHANNELS; i++) chans[i] = pick_chan();
        send_frame(FRAME_GOOD, chans, -1);
        tx_steady = 1'b0;
        run_random(300);

        // widest timeout, no idling on either side
        set_config(16'hFFFF, 8'hFF, 8'h00);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random(350);
        repeat (12) send_item(CMD_TICK, 8'($urandom));
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // limit dropped below the running count
        write_reg(REG_TIMEOUT_LIMIT, 16'd3);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'hFF);
        write_reg(REG_HEADER_LENGTH, 16'd32);
        write_reg(REG_HEADER_TYPE, 16'd64);
        run_random(350);

        // short random timeout, random headers
        set_config(16'($urandom_range(1, 40)), 8'($urandom), 8'($urandom));
        run_random(400);

        // drain
        push = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d items, %0d outputs checked, %0d frames taken, %0d with link lost",
                 sb.n_items, sb.n_results, sb.n_frames, sb.n_lost);
        $display("five register settings incl. timeout 0 and 65535, %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
